// File: sv/wkdc_pkg.sv
`default_nettype none

package wkdc_pkg;

	// Word and dictionary geometry
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned DICT_ROWS = 4;
	localparam int unsigned ROW_WAYS  = 4;
	localparam int unsigned ROW_AW    = $clog2(DICT_ROWS);
	localparam int unsigned WAY_AW    = $clog2(ROW_WAYS);
	localparam int unsigned ROW_BITS  = WORD_W * ROW_WAYS;
	localparam int unsigned LOW_W     = 10;

	localparam logic [WORD_W-1:0] ENTRY_RESET = 32'h0000_0001;

	// Code format, left-aligned in CODE_W bits
	localparam int unsigned CODE_W = 34;
	localparam int unsigned LEN_W  = 6;

	localparam logic [1:0] TAG_ZERO    = 2'b00;
	localparam logic [1:0] TAG_PARTIAL = 2'b01;
	localparam logic [1:0] TAG_MISS    = 2'b10;
	localparam logic [1:0] TAG_EXACT   = 2'b11;

	localparam logic [LEN_W-1:0] LEN_ZERO    = 6'd2;
	localparam logic [LEN_W-1:0] LEN_EXACT   = 6'd6;
	localparam logic [LEN_W-1:0] LEN_PARTIAL = 6'd16;
	localparam logic [LEN_W-1:0] LEN_MISS    = 6'd34;

	// Page byte count
	localparam int unsigned MAX_PAGE_WORDS = 1024;
	localparam int unsigned CNT_W          = 11;
	localparam int unsigned BYTES_W        = 13;
	localparam int unsigned WORD_CAP       = 2047;
	localparam int unsigned BYTE_BOUND     = ((MAX_PAGE_WORDS * 34 + 31) / 32) * 4;
	localparam int unsigned BYTE_CAP       = WORD_CAP * 4;
	localparam logic [BYTES_W-1:0] BYTE_LIMIT =
		BYTES_W'(BYTE_BOUND < BYTE_CAP ? BYTE_BOUND : BYTE_CAP);

	// Result queue
	localparam int unsigned MAX_RES = 3;
	localparam int unsigned Q_DEPTH = 16;

	typedef struct packed {
		logic              valid;
		logic              last;
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] bits;
	} code_t;

	typedef struct packed {
		logic [WORD_W-1:0]  word;
		logic               run_last;
		logic               page_done;
		logic [BYTES_W-1:0] bytes;
	} result_t;

	typedef struct packed {
		logic [1:0]            n;
		result_t [MAX_RES-1:0] res;
	} push_t;

	// Set selection by word bits 17..10, as a dictionary row number
	localparam logic [ROW_AW-1:0] SET_ROW [256] = '{
		2,0,2,1,0,2,1,2,2,0,0,3,3,0,2,2,
		3,1,0,1,2,1,1,1,2,1,2,0,3,1,3,2,
		3,0,2,0,3,1,0,0,3,0,2,1,2,2,1,2,
		3,3,2,1,0,2,2,2,0,0,1,3,0,3,2,2,
		2,2,3,1,2,2,3,3,2,3,3,1,2,1,1,2,
		1,2,0,0,0,0,0,1,1,1,1,1,0,3,0,3,
		1,3,2,0,1,1,2,1,3,1,2,3,3,2,2,0,
		3,1,1,2,2,2,0,1,3,2,1,0,2,0,1,0,
		2,1,2,3,3,3,1,0,2,3,0,0,0,3,0,1,
		0,3,1,0,2,1,3,0,1,0,1,3,3,2,1,2,
		0,1,0,0,1,0,0,0,0,3,0,3,2,0,2,1,
		0,2,1,1,3,0,3,0,3,0,2,3,2,2,3,1,
		3,3,3,2,2,3,2,3,3,3,2,0,0,1,2,0,
		3,1,0,1,1,0,1,3,1,0,3,3,1,0,1,0,
		3,0,3,2,3,0,1,3,1,1,3,3,3,0,3,1,
		2,0,3,1,2,0,1,1,3,2,1,3,2,3,2,0
	};

endpackage

`default_nettype wire

// File: sv/wkdc_dict.sv
`default_nettype none

module wkdc_dict import wkdc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [WORD_W-1:0] in_word,
	input  wire logic              in_last,
	output code_t                  code
);

	logic [ROW_BITS-1:0] mem [DICT_ROWS];

	logic                v_s1;
	logic                last_s1;
	logic [WORD_W-1:0]   word_s1;
	logic [ROW_AW-1:0]   row_s1;
	logic [ROW_BITS-1:0] rdata_s1;

	logic [DICT_ROWS-1:0] row_vld_q;
	logic                 fwd_v_q;
	logic [ROW_AW-1:0]    fwd_row_q;
	logic [ROW_BITS-1:0]  fwd_data_q;

	logic [ROW_AW-1:0]   in_row;
	logic [ROW_BITS-1:0] cur_row;
	logic [ROW_BITS-1:0] new_row;
	logic [WORD_W-1:0]   ent [ROW_WAYS];
	logic [ROW_WAYS-1:0] match;
	logic                hit;
	logic [WAY_AW-1:0]   pos;
	logic [WAY_AW-1:0]   shift_to;
	logic                wr_en;

	assign in_row = SET_ROW[in_word[17:10]];

	always_ff @(posedge clk) begin
		if (in_valid) begin
			rdata_s1 <= mem[in_row];
		end
		if (wr_en) begin
			mem[row_s1] <= new_row;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			word_s1 <= in_word;
			last_s1 <= in_last;
			row_s1  <= in_row;
		end
		if (wr_en) begin
			fwd_row_q  <= row_s1;
			fwd_data_q <= new_row;
		end
	end

	// Page end drops every row back to its reset contents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			row_vld_q <= '0;
			fwd_v_q   <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			if (v_s1 && last_s1) begin
				row_vld_q <= '0;
				fwd_v_q   <= 1'b0;
			end else if (wr_en) begin
				row_vld_q[row_s1] <= 1'b1;
				fwd_v_q           <= 1'b1;
			end
		end
	end

	always_comb begin
		if (fwd_v_q && (fwd_row_q == row_s1)) begin
			cur_row = fwd_data_q;
		end else if (row_vld_q[row_s1]) begin
			cur_row = rdata_s1;
		end else begin
			cur_row = {ROW_WAYS{ENTRY_RESET}};
		end
		for (int p = 0; p < ROW_WAYS; p++) begin
			ent[p]   = cur_row[p*WORD_W +: WORD_W];
			match[p] = (ent[p][WORD_W-1:LOW_W] == word_s1[WORD_W-1:LOW_W]);
		end
		hit = |match;
		pos = '0;
		for (int p = ROW_WAYS - 1; p >= 0; p--) begin
			if (match[p]) begin
				pos = WAY_AW'(p);
			end
		end
		shift_to = hit ? pos : WAY_AW'(ROW_WAYS - 1);
		new_row  = cur_row;
		new_row[0 +: WORD_W] = word_s1;
		for (int j = 1; j < ROW_WAYS; j++) begin
			if (WAY_AW'(j) <= shift_to) begin
				new_row[j*WORD_W +: WORD_W] = ent[j-1];
			end
		end
	end

	assign wr_en = v_s1 && !last_s1 && (word_s1 != '0);

	always_comb begin
		code.valid = v_s1;
		code.last  = last_s1;
		if (word_s1 == '0) begin
			code.len  = LEN_ZERO;
			code.bits = {TAG_ZERO, {(CODE_W-2){1'b0}}};
		end else if (hit && (ent[pos] == word_s1)) begin
			code.len  = LEN_EXACT;
			code.bits = {TAG_EXACT, row_s1, pos, {(CODE_W-6){1'b0}}};
		end else if (hit) begin
			code.len  = LEN_PARTIAL;
			code.bits = {TAG_PARTIAL, row_s1, pos, word_s1[LOW_W-1:0], {(CODE_W-16){1'b0}}};
		end else begin
			code.len  = LEN_MISS;
			code.bits = {TAG_MISS, word_s1};
		end
	end

endmodule

`default_nettype wire

// File: sv/wkdc_pack.sv
`default_nettype none

module wkdc_pack import wkdc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire code_t code,
	output push_t      push,
	output logic       busy
);

	logic              v_s2;
	logic              last_s2;
	logic [LEN_W-1:0]  len_s2;
	logic [CODE_W-1:0] bits_s2;

	logic [WORD_W-1:0] acc_q;
	logic [4:0]        fill_q;
	logic [CNT_W-1:0]  emitted_q;

	logic [95:0]        win;
	logic [6:0]         total;
	logic [1:0]         full_n;
	logic [WORD_W-1:0]  nacc;
	logic               flush;
	logic [1:0]         nw;
	logic [CNT_W:0]     sum;
	logic [CNT_W-1:0]   words_tot;
	logic [BYTES_W-1:0] bytes_raw;
	logic [BYTES_W-1:0] bytes;
	logic [WORD_W-1:0]  rword [MAX_RES];

	always_ff @(posedge clk) begin
		if (code.valid) begin
			last_s2 <= code.last;
			len_s2  <= code.len;
			bits_s2 <= code.bits;
		end
	end

	always_comb begin
		win   = {acc_q, 64'b0} | ({bits_s2, 62'b0} >> fill_q);
		total = {2'b00, fill_q} + {1'b0, len_s2};
		if (total[6]) begin
			full_n = 2'd2;
			nacc   = win[31:0];
		end else if (total[5]) begin
			full_n = 2'd1;
			nacc   = win[63:32];
		end else begin
			full_n = 2'd0;
			nacc   = win[95:64];
		end
		flush = last_s2 && (total[4:0] != 5'd0);
		nw    = full_n + {1'b0, flush};
		sum   = {1'b0, emitted_q} + {{(CNT_W-1){1'b0}}, nw};
		words_tot = (sum > (CNT_W+1)'(WORD_CAP)) ? CNT_W'(WORD_CAP) : sum[CNT_W-1:0];
		bytes_raw = {words_tot, 2'b00};
		bytes     = (bytes_raw > BYTE_LIMIT) ? BYTE_LIMIT : bytes_raw;
		rword[0]  = (full_n == 2'd0) ? nacc : win[95:64];
		rword[1]  = (full_n == 2'd1) ? nacc : win[63:32];
		rword[2]  = nacc;
		push.n = v_s2 ? nw : 2'd0;
		for (int i = 0; i < MAX_RES; i++) begin
			push.res[i].word      = rword[i];
			push.res[i].run_last  = (2'(i) == nw - 2'd1);
			push.res[i].page_done = push.res[i].run_last && last_s2;
			push.res[i].bytes     = push.res[i].page_done ? bytes : '0;
		end
	end

	// Page end restarts the packer and the word count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			acc_q     <= '0;
			fill_q    <= '0;
			emitted_q <= '0;
		end else begin
			v_s2 <= code.valid;
			if (v_s2) begin
				if (last_s2) begin
					acc_q     <= '0;
					fill_q    <= '0;
					emitted_q <= '0;
				end else begin
					acc_q     <= nacc;
					fill_q    <= total[4:0];
					emitted_q <= words_tot;
				end
			end
		end
	end

	assign busy = v_s2;

endmodule

`default_nettype wire

// File: sv/wkdc_outq.sv
`default_nettype none

module wkdc_outq import wkdc_pkg::*; #(
	parameter int unsigned DEPTH = Q_DEPTH
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire push_t                      push,
	input  wire logic                       pop,
	output result_t                         head,
	output logic                            not_empty,
	output logic [$clog2(DEPTH+1)-1:0]      count
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH+1);

	result_t       q_mem [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] waddr [MAX_RES];
	logic [AW:0]   wsum  [MAX_RES];
	logic [AW:0]   wr_next;
	logic [AW:0]   rd_next;

	always_comb begin
		for (int i = 0; i < MAX_RES; i++) begin
			wsum[i]  = {1'b0, wr_q} + (AW+1)'(i);
			waddr[i] = (wsum[i] >= (AW+1)'(DEPTH)) ? AW'(wsum[i] - (AW+1)'(DEPTH))
			                                       : wsum[i][AW-1:0];
		end
		wr_next = {1'b0, wr_q} + {{(AW-1){1'b0}}, push.n};
		rd_next = {1'b0, rd_q} + (AW+1)'(1);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (2'(i) < push.n) begin
				q_mem[waddr[i]] <= push.res[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q <= (wr_next >= (AW+1)'(DEPTH)) ? AW'(wr_next - (AW+1)'(DEPTH))
			                                   : wr_next[AW-1:0];
			if (pop) begin
				rd_q <= (rd_next >= (AW+1)'(DEPTH)) ? '0 : rd_next[AW-1:0];
			end
			count_q <= count_q + CW'(push.n) - CW'(pop);
		end
	end

	assign head      = q_mem[rd_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

endmodule

`default_nettype wire

// File: sv/wk_dictionary_word_compressor_top.sv
// An accepted word passes the dictionary and packer stage registers and the result queue to the master side.
// Throughput: one word per cycle in while ready is high; one result per cycle out while the master takes it,
// up to three results per word. Ready drops only while the result queue lacks room for the words still in flight.
// Reset (arst_n low) clears the pipeline, packer, count and queue at once; dictionary rows
// are marked unwritten and read back as all entries one. Page end restores the dictionary, packer and count likewise.
`default_nettype none

module wk_dictionary_word_compressor_top import wkdc_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = Q_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] data_word
	input  wire logic        s_tlast,   // page_last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [31:0] packed_word, [44:32] compressed_bytes, rest zero
	output logic             m_tlast,   // page_done
	output logic [0:0]       m_tuser    // [0] run_last
);

	localparam int unsigned CW    = $clog2(QUEUE_DEPTH+1);
	localparam int unsigned LVL_W = CW + 2;

	code_t         code;
	push_t         push;
	logic          pack_busy;
	result_t       head;
	logic          q_valid;
	logic [CW-1:0] q_count;
	logic          accept;
	logic          pop;
	logic [LVL_W-1:0] level;

	// Stage 1: set lookup, row read, match and move-to-front write back
	wkdc_dict u_dict (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.in_word  (s_tdata),
		.in_last  (s_tlast),
		.code     (code)
	);

	// Stage 2: bit packer, flush and page byte count
	wkdc_pack u_pack (
		.clk    (clk),
		.arst_n (arst_n),
		.code   (code),
		.push   (push),
		.busy   (pack_busy)
	);

	// Result queue decouples the packer bursts from the master side
	wkdc_outq #(
		.DEPTH (QUEUE_DEPTH)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.head      (head),
		.not_empty (q_valid),
		.count     (q_count)
	);

	// Reserve worst-case room for every word in flight plus the incoming one
	assign level = LVL_W'(q_count) + LVL_W'(MAX_RES)
	             + (code.valid ? LVL_W'(MAX_RES) : '0)
	             + (pack_busy  ? LVL_W'(MAX_RES) : '0);

	assign s_tready = (level <= LVL_W'(QUEUE_DEPTH));
	assign accept   = s_tvalid && s_tready;
	assign pop      = m_tvalid && m_tready;

	assign m_tvalid = q_valid;
	assign m_tdata  = {3'b000, head.bytes, head.word};
	assign m_tlast  = head.page_done;
	assign m_tuser  = head.run_last;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= CW'(QUEUE_DEPTH))
		else $error("result queue overflow");

	a_done_is_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tuser[0])
		else $error("page end not on the final result of its request");

	a_bytes_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tdata[44:32] == '0))
		else $error("byte count outside page end");

	a_request_reaches_packer: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 pack_busy)
		else $error("accepted request lost before the packer");

endmodule

`default_nettype wire

// File: sim/wk_dictionary_word_compressor_top_tb.sv
`timescale 1ns / 100ps

module wk_dictionary_word_compressor_top_tb import wkdc_pkg::*;;

	localparam int unsigned STALL_LIMIT = 3000;   // cycles with no request moved
	localparam int unsigned HISTORY_LEN = 12;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;       // [31:0] data_word
	logic        s_tlast = 1'b0;     // page_last
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;            // [31:0] packed_word, [44:32] compressed_bytes
	logic        m_tlast;            // page_done
	logic [0:0]  m_tuser;            // [0] run_last

	wk_dictionary_word_compressor_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	// Pacing knobs, in percent of cycles
	int unsigned src_idle_pct = 0;
	int unsigned snk_stall_pct = 0;
	int unsigned hold_left = 0;      // cycles the receiver still holds off
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;

	// Mirror of the compressor state
	logic [31:0] dict_entry [16];
	logic [31:0] pack_acc;
	int unsigned pack_free;
	int unsigned page_word_cnt;
	logic [31:0] step_out [$];       // packed words produced by the current request
	result_t     pending_packed [$]; // packed words still owed by the block
	logic [31:0] recent_words [$];   // nonzero words sent lately, reused for hits

	// ---------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------

	// Restore dictionary, packer and count, as after reset or page end
	function automatic void clear_page();
		foreach (dict_entry[i]) dict_entry[i] = ENTRY_RESET;
		pack_acc = '0;
		pack_free = 32;
		page_word_cnt = 0;
	endfunction

	function automatic void emit_packed(logic [31:0] w);
		step_out.push_back(w);
		if (page_word_cnt < WORD_CAP) page_word_cnt++;
	endfunction

	// Shift n bits (MSB first) into the packer; emit a word whenever it fills
	function automatic void append_bits(logic [63:0] val, int unsigned n);
		logic [63:0] v;
		logic [63:0] w;
		int unsigned rest;
		v = val & ((64'd1 << n) - 64'd1);
		if (n < pack_free) begin
			w = ({32'd0, pack_acc} << n) | v;
			pack_acc = w[31:0];
			pack_free -= n;
		end else begin
			rest = n - pack_free;
			w = ({32'd0, pack_acc} << pack_free) | (v >> rest);
			emit_packed(w[31:0]);
			v = v & ((64'd1 << rest) - 64'd1);
			pack_acc = v[31:0];
			pack_free = 32 - rest;
		end
	endfunction

	// Move the entry at pos to the front of its set; pos 0 just overwrites
	function automatic void promote(logic [3:0] base, int unsigned pos, logic [31:0] word);
		for (int k = pos; k > 0; k--)
			dict_entry[base + k] = dict_entry[base + k - 1];
		dict_entry[base] = word;
	endfunction

	function automatic void code_word(logic [31:0] word);
		logic [3:0] base;
		logic [3:0] idx;
		if (word == '0) begin
			append_bits(TAG_ZERO, LEN_ZERO);
			return;
		end
		base = {SET_ROW[word[17:10]], 2'b00};
		for (int pos = 0; pos < ROW_WAYS; pos++) begin
			idx = base + 4'(pos);
			// Only bits 31..10 decide a hit; low bits pick exact vs partial
			if (dict_entry[idx][31:10] == word[31:10]) begin
				if (dict_entry[idx] == word)
					append_bits({TAG_EXACT, idx}, LEN_EXACT);
				else
					append_bits({TAG_PARTIAL, idx, word[9:0]}, LEN_PARTIAL);
				promote(base, pos, word);
				return;
			end
		end
		// Miss: tag and word go in as two separate pushes into the packer
		append_bits(TAG_MISS, 2);
		append_bits(word, WORD_W);
		promote(base, ROW_WAYS - 1, word);
	endfunction

	// Work out the packed words one accepted request causes
	function automatic void predict_request(logic [31:0] word, logic last);
		logic [BYTES_W-1:0] bytes;
		int unsigned n;
		result_t r;
		step_out.delete();
		code_word(word);
		bytes = '0;
		if (last) begin
			// Flush the partial word left-aligned
			if (pack_free < 32) emit_packed(pack_acc << pack_free);
			if (page_word_cnt * 4 > BYTE_LIMIT) bytes = BYTE_LIMIT;
			else bytes = BYTES_W'(page_word_cnt * 4);
		end
		n = (step_out.size() > MAX_RES) ? MAX_RES : step_out.size();
		for (int k = 0; k < n; k++) begin
			r.word = step_out[k];
			r.run_last = (k == n - 1);
			r.page_done = r.run_last && last;
			r.bytes = r.page_done ? bytes : '0;
			pending_packed.push_back(r);
		end
		if (last) clear_page();
	endfunction

	// ---------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------

	task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			mismatches++;
			$display("%0t ns: %s expected %h, got %h", $time, name, exp_v, got_v);
		end
	endtask

	// Compare every accepted packed word with the oldest one owed
	always @(posedge clk) begin
		result_t owed;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_packed.size() == 0) begin
				mismatches++;
				$display("%0t ns: unexpected packed word, expected none, got %h",
					$time, m_tdata);
			end else begin
				owed = pending_packed.pop_front();
				report_field("packed_word", owed.word, m_tdata[31:0]);
				report_field("compressed_bytes", 32'(owed.bytes), 32'(m_tdata[44:32]));
				report_field("page_done", 32'(owed.page_done), 32'(m_tlast));
				report_field("run_last", 32'(owed.run_last), 32'(m_tuser[0]));
			end
		end
	end

	// Receiver: hold off for a counted stretch when asked, else stall at random
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// Watchdog: end the run if no request moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t ns: watchdog, no request moved, %0d packed words owed",
					$time, pending_packed.size());
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------

	// Offer one word; called and returns at a falling edge
	task automatic send_word(logic [31:0] word, logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		predict_request(word, last);
		@(negedge clk);
	endtask

	// Drop valid and wait until every owed packed word has come back
	task automatic pause_until_drained();
		s_tvalid <= 1'b0;
		while (pending_packed.size() != 0) @(negedge clk);
	endtask

	// Mostly words that hit the dictionary, with zeros, set thrashing and fresh misses
	function automatic logic [31:0] pick_word();
		logic [31:0] w;
		logic [31:0] h;
		int unsigned mode;
		mode = $urandom_range(99);
		h = (recent_words.size() != 0) ?
			recent_words[$urandom_range(recent_words.size() - 1)] : $urandom;
		if (mode < 12) w = '0;
		else if (mode < 40) w = h;
		else if (mode < 62) w = {h[31:10], 10'($urandom)};
		else if (mode < 70) w = $urandom_range(1023);
		else if (mode < 78) w = {14'($urandom), h[17:10], 10'($urandom)};
		else w = $urandom;
		if (w != '0) begin
			recent_words.push_back(w);
			if (recent_words.size() > HISTORY_LEN) void'(recent_words.pop_front());
		end
		return w;
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Each code kind, LRU moves, in-place overwrite and short pages
	task automatic test_code_kinds();
		src_idle_pct = 0;
		snk_stall_pct = 0;
		send_word(32'h0000_0000, 1'b1);   // page of one zero word, flush only
		send_word(32'hFFFF_FFFF, 1'b1);   // page of one miss, two packed words
		send_word(32'h0000_0001, 1'b0);   // exact on a reset entry
		send_word(32'h0000_03FF, 1'b0);   // partial at the front, overwrite in place
		send_word(32'h1000_0000, 1'b0);   // fill one set with misses
		send_word(32'h2000_0000, 1'b0);
		send_word(32'h3000_0000, 1'b0);
		send_word(32'h4000_0000, 1'b0);
		send_word(32'h1000_0000, 1'b0);   // exact at the back, move to front
		send_word(32'h3000_0155, 1'b0);   // partial in the middle
		send_word(32'h3000_0155, 1'b0);   // now exact at the front
		send_word(32'hFFFF_FC00, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'h0000_0000, 1'b1);
		pause_until_drained();
	endtask

	// Two partials fill the packer exactly; the page ends with no flush word
	task automatic test_pack_boundary();
		send_word(32'h0000_0002, 1'b0);
		send_word(32'h0000_0003, 1'b1);
		pause_until_drained();
	endtask

	// Random pages under one pacing setting; close the last page
	task automatic test_traffic(int unsigned items, int unsigned src_pct,
		int unsigned snk_pct);
		int unsigned page_left;
		src_idle_pct = src_pct;
		snk_stall_pct = snk_pct;
		page_left = $urandom_range(1, 40);
		for (int unsigned i = 0; i < items; i++) begin
			page_left--;
			send_word(pick_word(), (page_left == 0) || (i == items - 1));
			if (page_left == 0) page_left = $urandom_range(1, 40);
		end
		pause_until_drained();
	endtask

	// Receiver holds off while misses keep coming, so the block fills and stalls
	task automatic test_backpressure();
		int unsigned page_left;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		@(posedge clk);
		hold_left = 300;
		@(negedge clk);
		page_left = $urandom_range(4, 20);
		for (int unsigned i = 0; i < 90; i++) begin
			page_left--;
			send_word($urandom | 32'h0004_0000, (page_left == 0) || (i == 89));
			if (page_left == 0) page_left = $urandom_range(4, 20);
		end
		pause_until_drained();
	endtask

	// Long page of misses: the byte count runs over many packed words
	task automatic test_long_page();
		src_idle_pct = 0;
		snk_stall_pct = 0;
		for (int unsigned i = 0; i < 70; i++)
			send_word($urandom | 32'h8000_0000, i == 69);
		pause_until_drained();
	endtask

	initial begin
		clear_page();
		// Hold reset, then release it on a falling edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_code_kinds();
		test_pack_boundary();
		test_traffic(60, 0, 0);
		test_traffic(60, 77, 0);
		test_traffic(60, 0, 77);
		test_traffic(60, 12, 12);
		test_backpressure();
		test_long_page();

		// Let any late output show up before judging
		while (pending_packed.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// File: sim.f
sv/wkdc_pkg.sv
sv/wkdc_dict.sv
sv/wkdc_pack.sv
sv/wkdc_outq.sv
sv/wk_dictionary_word_compressor_top.sv
sim/wk_dictionary_word_compressor_top_tb.sv
